// ----- hdl/sti_pkg.sv -----
// Shared constants and types for the sorted timestamp index.
package sti_pkg;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned RESULT_LIMIT = 64;
  localparam int unsigned ADDR_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1);
  localparam int unsigned RCNT_W       = $clog2(RESULT_LIMIT + 1);

  localparam int unsigned TS_W  = 32;
  localparam int unsigned ID_W  = 64;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OP_W  = 2;
  localparam int unsigned IN_W  = 128;
  localparam int unsigned OUT_W = 72;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_RANGE  = 2'd2;

  localparam logic [ST_W-1:0] STAT_OK   = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL = 2'd1;
  localparam logic [ST_W-1:0] STAT_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_REM_SCAN,
    S_REM_SHIFT,
    S_RNG,
    S_DONE
  } state_e;

endpackage

// ----- hdl/sorted_timestamp_index_unit.sv -----
// Sorted timestamp index: table memory, scan/shift sequencer and result register.
// Insert moves later-stamped entries up from the top; remove scans for the id and shifts
// the entries above it down; range scans upward from the bottom; sink stalls hold each.
// Range ids stream one beat per cycle while the sink is ready. tready returns the cycle after
// the final beat is loaded, so one request is taken at a time; one table read/write a cycle.
// Reset clears the entry count, sequencer and result valid; table memory is not cleared.
module sorted_timestamp_index_unit
  import sti_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave side: tdata = key_ts[31:0], upper_bound[63:32], message_id[127:64]
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // tuser = op[1:0]
  input  logic [OP_W-1:0]  s_axis_tuser_i,
  // master side: tdata = status[1:0], found_id[65:2], zero pad [71:66]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  // Table memory: timestamp and id per entry, registered read port.
  logic [TS_W-1:0] stamp_mem [CAPACITY];
  logic [ID_W-1:0] ident_mem [CAPACITY];
  logic [TS_W-1:0] rd_stamp_q;
  logic [ID_W-1:0] rd_ident_q;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [TS_W-1:0]   wr_stamp;
  logic [ID_W-1:0]   wr_ident;

  // Sequencer state and latched request.
  state_e            state_q, state_d;
  logic [TS_W-1:0]   key_q, key_d;
  logic [TS_W-1:0]   upper_q, upper_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [ST_W-1:0]   status_q, status_d;
  // One range hit is held back until the next entry shows whether it is the last.
  logic              pend_q, pend_d;
  logic [ID_W-1:0]   pend_id_q, pend_id_d;
  logic [RCNT_W-1:0] rcnt_q, rcnt_d;

  // Result register.
  logic            out_valid_q;
  logic [ST_W-1:0] out_status_q;
  logic [ID_W-1:0] out_id_q;
  logic            out_last_q;
  logic            out_load;
  logic [ST_W-1:0] out_status;
  logic [ID_W-1:0] out_id;
  logic            out_last;

  logic            s_hs, out_free;
  logic [OP_W-1:0] in_op;
  logic [TS_W-1:0] in_key, in_upper;
  logic [ID_W-1:0] in_id;

  logic [CNT_W-1:0] ptr_inc, ptr_inc2, ptr_dec, ptr_dec2, cnt_dec, cnt_inc;
  logic             tbl_full, tbl_empty, last_ent, shift_end;
  logic             ins_move, id_hit, in_rng, above_hi, limit_hit;

  assign in_op    = s_axis_tuser_i;
  assign in_key   = s_axis_tdata_i[31:0];
  assign in_upper = s_axis_tdata_i[63:32];
  assign in_id    = s_axis_tdata_i[127:64];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_hs            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign ptr_inc  = ptr_q + CNT_W'(1);
  assign ptr_inc2 = ptr_q + CNT_W'(2);
  assign ptr_dec  = ptr_q - CNT_W'(1);
  assign ptr_dec2 = ptr_q - CNT_W'(2);
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign cnt_inc  = cnt_q + CNT_W'(1);

  assign tbl_full  = (cnt_q == CNT_W'(CAPACITY));
  assign tbl_empty = (cnt_q == '0);
  assign last_ent  = (ptr_inc == cnt_q);
  assign shift_end = (ptr_inc2 == cnt_q);

  // Shared compare unit on the entry just read.
  assign ins_move  = (rd_stamp_q > key_q);
  assign id_hit    = (rd_ident_q == id_q);
  assign above_hi  = (rd_stamp_q > upper_q);
  assign in_rng    = (rd_stamp_q >= key_q) && !above_hi;
  assign limit_hit = (rcnt_q == RCNT_W'(RESULT_LIMIT - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_hs) begin
          case (in_op)
            OP_INSERT: begin
              if (tbl_full) state_d = S_DONE;
              else if (tbl_empty) state_d = S_INS_PUT;
              else state_d = S_INS;
            end
            OP_REMOVE: state_d = tbl_empty ? S_DONE : S_REM_SCAN;
            OP_RANGE:  state_d = tbl_empty ? S_DONE : S_RNG;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (!ins_move) state_d = S_DONE;
        else if (ptr_q == CNT_W'(1)) state_d = S_INS_PUT;
      end
      S_INS_PUT: state_d = S_DONE;
      S_REM_SCAN: begin
        if (last_ent) state_d = S_DONE;
        else if (id_hit) state_d = S_REM_SHIFT;
      end
      S_REM_SHIFT: begin
        if (shift_end) state_d = S_DONE;
      end
      S_RNG: begin
        if (out_free) begin
          if (in_rng) begin
            if (pend_q && limit_hit) state_d = S_IDLE;
            else if (last_ent) state_d = S_DONE;
          end else if (above_hi || last_ent) begin
            state_d = pend_q ? S_IDLE : S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and memory access.
  always_comb begin
    key_d      = key_q;
    upper_d    = upper_q;
    id_d       = id_q;
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    status_d   = status_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    rcnt_d     = rcnt_q;
    wr_en      = 1'b0;
    wr_addr    = ptr_q[ADDR_W-1:0];
    wr_stamp   = rd_stamp_q;
    wr_ident   = rd_ident_q;
    rd_en      = 1'b0;
    rd_addr    = ptr_inc[ADDR_W-1:0];
    out_load   = 1'b0;
    out_status = STAT_OK;
    out_id     = pend_id_q;
    out_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (s_hs) begin
          key_d     = in_key;
          upper_d   = in_upper;
          id_d      = in_id;
          pend_d    = 1'b0;
          pend_id_d = '0;
          rcnt_d    = '0;
          ptr_d     = '0;
          status_d  = STAT_NONE;
          case (in_op)
            OP_INSERT: begin
              // Start at the top: the target slot is the current count.
              status_d = tbl_full ? STAT_FULL : STAT_OK;
              ptr_d    = cnt_q;
              if (!tbl_full && !tbl_empty) begin
                rd_en   = 1'b1;
                rd_addr = cnt_dec[ADDR_W-1:0];
              end
            end
            OP_REMOVE, OP_RANGE: begin
              if (!tbl_empty) begin
                rd_en   = 1'b1;
                rd_addr = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        wr_en = 1'b1;
        if (ins_move) begin
          // Move the entry below up into the target slot and walk down.
          ptr_d = ptr_dec;
          if (ptr_q != CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = ptr_dec2[ADDR_W-1:0];
          end
        end else begin
          wr_stamp = key_q;
          wr_ident = id_q;
          cnt_d    = cnt_inc;
        end
      end
      S_INS_PUT: begin
        wr_en    = 1'b1;
        wr_stamp = key_q;
        wr_ident = id_q;
        cnt_d    = cnt_inc;
      end
      S_REM_SCAN: begin
        if (id_hit) begin
          status_d = STAT_OK;
          if (last_ent) begin
            cnt_d = cnt_dec;
          end else begin
            rd_en = 1'b1;
          end
        end else if (!last_ent) begin
          rd_en = 1'b1;
          ptr_d = ptr_inc;
        end
      end
      S_REM_SHIFT: begin
        // Entry above lands in the current slot.
        wr_en = 1'b1;
        ptr_d = ptr_inc;
        if (shift_end) begin
          cnt_d = cnt_dec;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc2[ADDR_W-1:0];
        end
      end
      S_RNG: begin
        if (out_free) begin
          if (in_rng) begin
            if (pend_q) begin
              out_load = 1'b1;
              out_last = limit_hit;
              rcnt_d   = rcnt_q + RCNT_W'(1);
            end
            if (!(pend_q && limit_hit)) begin
              pend_d    = 1'b1;
              pend_id_d = rd_ident_q;
              status_d  = STAT_OK;
              if (!last_ent) begin
                rd_en = 1'b1;
                ptr_d = ptr_inc;
              end
            end
          end else if (above_hi || last_ent) begin
            // Run ended: flush the held hit as the last beat.
            if (pend_q) begin
              out_load = 1'b1;
            end
          end else begin
            rd_en = 1'b1;
            ptr_d = ptr_inc;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = status_q;
        end
      end
      default: ;
    endcase
  end

  // Table memory.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      ident_mem[wr_addr] <= wr_ident;
    end
    if (rd_en) begin
      rd_stamp_q <= stamp_mem[rd_addr];
      rd_ident_q <= ident_mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    upper_q   <= upper_d;
    id_q      <= id_d;
    ptr_q     <= ptr_d;
    status_q  <= status_d;
    pend_id_q <= pend_id_d;
    rcnt_q    <= rcnt_d;
    if (out_load) begin
      out_status_q <= out_status;
      out_id_q     <= out_id;
      out_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_W - ID_W - ST_W)'(0), out_id_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
